// ===== sv/spcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcc_pkg
// Shared types, widths and constant tables for the pre-trigger count
// calculator.
// ----------------------------------------------------------------------------
package spcc_pkg;

  localparam int RANDOMIZE_MAX_BASE = 5;
  localparam int TB_MAX     = 30;
  localparam int PSEL_MAX   = 6;

  localparam int TB_W       = 5;
  localparam int TRIG_W     = 2;
  localparam int PSEL_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam int TS_W       = 15;
  localparam int SHIFT_W    = 17;
  localparam int PTS_W      = 15;
  localparam int ADD_W      = 5;
  localparam int DIDX_W     = 3;
  localparam int STEP_W     = 7;
  localparam int RECIP_W    = 24;
  localparam int RECIP_SH   = 24;
  localparam int MAG_W      = 15;
  localparam int PROD_W     = MAG_W + RECIP_W;
  localparam int QD_W       = MAG_W + STEP_W;
  localparam int Q_W        = 16;
  localparam int R_W        = 8;
  localparam int WORD_W     = 16;
  localparam int RD_W       = 16;
  localparam int SUM_W      = 20;

  // register stages inside spcc_div
  localparam int DIV_STAGES = 3;

  // divisor row used in real-time mode (step 2 gives shift / 2 and points / 2)
  localparam logic [DIDX_W-1:0] DIDX_REALTIME = DIDX_W'(5);

  typedef enum logic [TRIG_W-1:0] {
    TRIG_LEFT   = 2'd0,
    TRIG_CENTER = 2'd1,
    TRIG_RIGHT  = 2'd2
  } trig_pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_BASE  = 3'd0,
    CFG_TRIG_POS   = 3'd1,
    CFG_POINTS_SEL = 3'd2,
    CFG_PEAK_DET   = 3'd3
  } cfg_idx_t;

  localparam logic [PTS_W-1:0] POINTS_TAB [0:6] = '{
    15'd281, 15'd512, 15'd1024, 15'd2048, 15'd4096, 15'd8192, 15'd16384
  };

  localparam logic [STEP_W-1:0] STEP_TAB [0:5] = '{
    7'd100, 7'd50, 7'd20, 7'd10, 7'd5, 7'd2
  };

  // floor(2^24 / step)
  localparam logic [RECIP_W-1:0] RECIP_TAB [0:5] = '{
    24'd167772, 24'd335544, 24'd838860, 24'd1677721, 24'd3355443, 24'd8388608
  };

  // record points divided by each step, truncated
  localparam logic [PTS_W-1:0] PTS_DIV_TAB [0:5][0:6] = '{
    '{15'd2,   15'd5,   15'd10,  15'd20,   15'd40,   15'd81,   15'd163},
    '{15'd5,   15'd10,  15'd20,  15'd40,   15'd81,   15'd163,  15'd327},
    '{15'd14,  15'd25,  15'd51,  15'd102,  15'd204,  15'd409,  15'd819},
    '{15'd28,  15'd51,  15'd102, 15'd204,  15'd409,  15'd819,  15'd1638},
    '{15'd56,  15'd102, 15'd204, 15'd409,  15'd819,  15'd1638, 15'd3276},
    '{15'd140, 15'd256, 15'd512, 15'd1024, 15'd2048, 15'd4096, 15'd8192}
  };

  localparam logic [ADD_W-1:0] PRE_ADD_TAB [0:7] = '{
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd5, 5'd3
  };

  localparam logic [ADD_W-1:0] POST_ADD_TAB [0:7] = '{
    5'd10, 5'd10, 5'd20, 5'd10, 5'd10, 5'd10, 5'd5, 5'd3
  };

  // per-item data that rides alongside the divider stages
  typedef struct packed {
    logic [PTS_W-1:0]       pts_q;
    logic [ADD_W-1:0]       pre_add;
    logic [ADD_W-1:0]       post_add;
    logic                   equiv;
    logic                   peak;
    logic signed [RD_W-1:0] rd;
  } side_t;

endpackage

// ===== sv/spcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcc_front
// Configuration registers and first pipeline stage: table lookups, launch
// shift and divisor selection.
// ----------------------------------------------------------------------------
module spcc_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [spcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spcc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  input  logic signed [spcc_pkg::TS_W-1:0]      time_shift,
  output logic                                  s1_valid,
  output logic signed [spcc_pkg::SHIFT_W-1:0]   s1_shift,
  output logic signed [spcc_pkg::TS_W-1:0]      s1_tshift,
  output logic [spcc_pkg::DIDX_W-1:0]           s1_didx,
  output spcc_pkg::side_t                       s1_side
);

  logic [spcc_pkg::TB_W-1:0]   time_base;
  logic [spcc_pkg::TRIG_W-1:0] trigger_position;
  logic [spcc_pkg::PSEL_W-1:0] points_select;
  logic                        peak_detect;

  logic [spcc_pkg::TB_W-1:0]            base;
  logic [spcc_pkg::PSEL_W-1:0]          psel;
  logic [spcc_pkg::PTS_W-1:0]           points;
  logic [spcc_pkg::PTS_W-1:0]           ofs;
  logic signed [spcc_pkg::SHIFT_W-1:0]  shift_next;
  logic                                 equiv;
  logic [spcc_pkg::DIDX_W-1:0]          didx_next;
  spcc_pkg::side_t                      side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_base        <= '0;
      trigger_position <= '0;
      points_select    <= '0;
      peak_detect      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        spcc_pkg::CFG_TIME_BASE:  time_base        <= cfg_data[spcc_pkg::TB_W-1:0];
        spcc_pkg::CFG_TRIG_POS:   trigger_position <= cfg_data[spcc_pkg::TRIG_W-1:0];
        spcc_pkg::CFG_POINTS_SEL: points_select    <= cfg_data[spcc_pkg::PSEL_W-1:0];
        spcc_pkg::CFG_PEAK_DET:   peak_detect      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    base = (time_base > spcc_pkg::TB_W'(spcc_pkg::TB_MAX))
         ? spcc_pkg::TB_W'(spcc_pkg::TB_MAX) : time_base;
    psel = (points_select > spcc_pkg::PSEL_W'(spcc_pkg::PSEL_MAX))
         ? spcc_pkg::PSEL_W'(spcc_pkg::PSEL_MAX) : points_select;
    points = spcc_pkg::POINTS_TAB[psel];

    // minus the minimum shift; code 3 falls back to left
    case (trigger_position)
      spcc_pkg::TRIG_CENTER: ofs = spcc_pkg::PTS_DIV_TAB[spcc_pkg::DIDX_REALTIME][psel];
      spcc_pkg::TRIG_RIGHT:  ofs = '0;
      default:               ofs = points;
    endcase

    shift_next = spcc_pkg::SHIFT_W'(time_shift) + $signed({2'b00, ofs});
    equiv      = (base <= spcc_pkg::TB_W'(spcc_pkg::RANDOMIZE_MAX_BASE));
    didx_next  = equiv ? base[spcc_pkg::DIDX_W-1:0] : spcc_pkg::DIDX_REALTIME;

    side_next.pts_q    = spcc_pkg::PTS_DIV_TAB[didx_next][psel];
    side_next.pre_add  = (base < spcc_pkg::TB_W'(8))
                       ? spcc_pkg::PRE_ADD_TAB[base[2:0]] : spcc_pkg::ADD_W'(1);
    side_next.post_add = (base < spcc_pkg::TB_W'(8))
                       ? spcc_pkg::POST_ADD_TAB[base[2:0]] : spcc_pkg::ADD_W'(1);
    side_next.equiv    = equiv;
    side_next.peak     = peak_detect;
    side_next.rd       = shift_next[spcc_pkg::SHIFT_W-1]
                       ? shift_next[spcc_pkg::RD_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_shift  <= shift_next;
    s1_tshift <= time_shift;
    s1_didx   <= didx_next;
    s1_side   <= side_next;
  end

endmodule

// ===== sv/spcc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcc_div
// Three-stage truncating divider by one of the stretch steps: reciprocal
// multiply, back multiply, single correction, then sign restore.
// ----------------------------------------------------------------------------
module spcc_div (
  input  logic                                clk,
  input  logic signed [spcc_pkg::SHIFT_W-1:0] dividend,
  input  logic [spcc_pkg::DIDX_W-1:0]         didx,
  output logic signed [spcc_pkg::Q_W-1:0]     quo,
  output logic signed [spcc_pkg::R_W-1:0]     rem
);

  logic [spcc_pkg::SHIFT_W-1:0] abs_full;
  logic [spcc_pkg::MAG_W-1:0]   mag_in;

  logic                         neg_b;
  logic [spcc_pkg::MAG_W-1:0]   mag_b;
  logic [spcc_pkg::STEP_W-1:0]  d_b;
  logic [spcc_pkg::PROD_W-1:0]  prod_b;

  logic [spcc_pkg::MAG_W-1:0]   q0;
  logic                         neg_c;
  logic [spcc_pkg::MAG_W-1:0]   mag_c;
  logic [spcc_pkg::STEP_W-1:0]  d_c;
  logic [spcc_pkg::MAG_W-1:0]   q0_c;
  logic [spcc_pkg::QD_W-1:0]    qd_c;

  logic [spcc_pkg::Q_W-1:0]     rem_raw;
  logic                         fix;
  logic [spcc_pkg::MAG_W-1:0]   q_fix;
  logic [spcc_pkg::Q_W-1:0]     r_fix;
  logic signed [spcc_pkg::Q_W-1:0] q_s;
  logic signed [spcc_pkg::R_W-1:0] r_s;

  always_comb begin
    abs_full = dividend[spcc_pkg::SHIFT_W-1] ? -dividend : dividend;
    mag_in   = abs_full[spcc_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    neg_b  <= dividend[spcc_pkg::SHIFT_W-1];
    mag_b  <= mag_in;
    d_b    <= spcc_pkg::STEP_TAB[didx];
    prod_b <= spcc_pkg::PROD_W'(mag_in) * spcc_pkg::PROD_W'(spcc_pkg::RECIP_TAB[didx]);
  end

  // estimate is exact or one low
  assign q0 = prod_b[spcc_pkg::RECIP_SH +: spcc_pkg::MAG_W];

  always_ff @(posedge clk) begin
    neg_c <= neg_b;
    mag_c <= mag_b;
    d_c   <= d_b;
    q0_c  <= q0;
    qd_c  <= spcc_pkg::QD_W'(q0) * spcc_pkg::QD_W'(d_b);
  end

  always_comb begin
    rem_raw = spcc_pkg::Q_W'(mag_c) - qd_c[spcc_pkg::Q_W-1:0];
    fix     = (rem_raw >= spcc_pkg::Q_W'(d_c));
    q_fix   = q0_c + spcc_pkg::MAG_W'(fix);
    r_fix   = fix ? (rem_raw - spcc_pkg::Q_W'(d_c)) : rem_raw;
    q_s     = $signed({1'b0, q_fix});
    r_s     = $signed(r_fix[spcc_pkg::R_W-1:0]);
  end

  always_ff @(posedge clk) begin
    quo <= neg_c ? -q_s : q_s;
    rem <= neg_c ? -r_s : r_s;
  end

endmodule

// ===== sv/spcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcc_back
// Final stage: pre/post counts, table deltas, peak-detect doubling,
// counter word inversion and the output register.
// ----------------------------------------------------------------------------
module spcc_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  spcc_pkg::side_t                    side,
  input  logic signed [spcc_pkg::Q_W-1:0]    quo,
  input  logic signed [spcc_pkg::R_W-1:0]    rem,
  output logic                               done,
  output logic [spcc_pkg::WORD_W-1:0]        pre_word,
  output logic [spcc_pkg::WORD_W-1:0]        post_word,
  output logic signed [spcc_pkg::RD_W-1:0]   read_delta,
  output logic signed [spcc_pkg::R_W-1:0]    first_offset,
  output logic                               equivalent_mode
);

  logic signed [spcc_pkg::SUM_W-1:0] q_ext;
  logic signed [spcc_pkg::SUM_W-1:0] pts_ext;
  logic signed [spcc_pkg::SUM_W-1:0] pre;
  logic signed [spcc_pkg::SUM_W-1:0] post;
  logic signed [spcc_pkg::SUM_W-1:0] pre_sum;
  logic signed [spcc_pkg::SUM_W-1:0] post_sum;
  logic signed [spcc_pkg::SUM_W-1:0] pre_fin;
  logic signed [spcc_pkg::SUM_W-1:0] post_fin;

  always_comb begin
    q_ext   = spcc_pkg::SUM_W'(quo);
    pts_ext = $signed({{(spcc_pkg::SUM_W-spcc_pkg::PTS_W){1'b0}}, side.pts_q});
    pre     = pts_ext - q_ext;
    post    = q_ext;
    if (!side.equiv) begin
      // real time: counts never go negative
      if (pre < 0) pre = '0;
      if (q_ext < 0) post = '0;
    end
    pre_sum  = pre + $signed({{(spcc_pkg::SUM_W-spcc_pkg::ADD_W){1'b0}}, side.pre_add});
    post_sum = post + $signed({{(spcc_pkg::SUM_W-spcc_pkg::ADD_W){1'b0}}, side.post_add});
    pre_fin  = side.peak ? (pre_sum <<< 1) : pre_sum;
    post_fin = side.peak ? (post_sum <<< 1) : post_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pre_word        <= ~pre_fin[spcc_pkg::WORD_W-1:0];
    post_word       <= ~post_fin[spcc_pkg::WORD_W-1:0];
    read_delta      <= side.rd;
    first_offset    <= side.equiv ? -rem : '0;
    equivalent_mode <= side.equiv;
  end

endmodule

// ===== sv/scope_pretrigger_count_calc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_pretrigger_count_calc_core
// Acquisition launch calculator: time shift in, counter words, read delta
// and first-index offset out.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write time_base, trigger_position, points_select and
//   peak_detect over cfg_valid/cfg_ready with cfg_index/cfg_data while no
//   item is in flight. Unknown indexes are ignored.
//   Command: a transaction is taken at a clock edge with start high and
//   busy low. busy is high only while reset is applied and up to the first
//   clock edge with reset low, so a new time_shift may be issued every cycle.
//   Result: done pulses for one cycle with all result ports valid, once the
//   command has passed the front stage, three divider stages and the output
//   register. One result per command, in order; throughput is one per clock.
//   The result ports are not held, so the receiver must take each result in
//   its done cycle.
//   Reset (rst, synchronous): configuration returns to zero and all items
//   in flight are dropped; done stays low until new commands arrive.
// ----------------------------------------------------------------------------
module scope_pretrigger_count_calc_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spcc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [spcc_pkg::TS_W-1:0]      time_shift,
  output logic                                  done,
  output logic [spcc_pkg::WORD_W-1:0]           pre_word,
  output logic [spcc_pkg::WORD_W-1:0]           post_word,
  output logic signed [spcc_pkg::RD_W-1:0]      read_delta,
  output logic signed [spcc_pkg::R_W-1:0]       first_offset,
  output logic                                  equivalent_mode
);

  logic                                  s1_valid;
  logic signed [spcc_pkg::SHIFT_W-1:0]   s1_shift;
  logic signed [spcc_pkg::TS_W-1:0]      s1_tshift;
  logic [spcc_pkg::DIDX_W-1:0]           s1_didx;
  spcc_pkg::side_t                       s1_side;

  logic [spcc_pkg::DIV_STAGES-1:0]       vpipe;
  spcc_pkg::side_t                       spipe [spcc_pkg::DIV_STAGES];

  logic signed [spcc_pkg::Q_W-1:0]       shift_quo;
  logic signed [spcc_pkg::R_W-1:0]       ts_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = ~busy;

  spcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (start & ~busy),
    .time_shift (time_shift),
    .s1_valid   (s1_valid),
    .s1_shift   (s1_shift),
    .s1_tshift  (s1_tshift),
    .s1_didx    (s1_didx),
    .s1_side    (s1_side)
  );

  // launch shift over step (or over two in real time)
  spcc_div u_div_shift (
    .clk      (clk),
    .dividend (s1_shift),
    .didx     (s1_didx),
    .quo      (shift_quo),
    .rem      ()
  );

  // time shift remainder for the first-index offset
  spcc_div u_div_ts (
    .clk      (clk),
    .dividend (spcc_pkg::SHIFT_W'(s1_tshift)),
    .didx     (s1_didx),
    .quo      (),
    .rem      (ts_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[spcc_pkg::DIV_STAGES-2:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    spipe[0] <= s1_side;
    for (int i = 1; i < spcc_pkg::DIV_STAGES; i++) begin
      spipe[i] <= spipe[i-1];
    end
  end

  spcc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (vpipe[spcc_pkg::DIV_STAGES-1]),
    .side            (spipe[spcc_pkg::DIV_STAGES-1]),
    .quo             (shift_quo),
    .rem             (ts_rem),
    .done            (done),
    .pre_word        (pre_word),
    .post_word       (post_word),
    .read_delta      (read_delta),
    .first_offset    (first_offset),
    .equivalent_mode (equivalent_mode)
  );

endmodule

// ===== sv/spcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcc_checker
// Port-level checks for the pre-trigger count calculator.
// ----------------------------------------------------------------------------
module spcc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  done,
  input logic signed [spcc_pkg::RD_W-1:0]      read_delta,
  input logic signed [spcc_pkg::R_W-1:0]       first_offset,
  input logic                                  equivalent_mode
);

  // reset flushes every transaction in flight
  a_rst_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted command produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without command");

  a_rt_offset: assert property (@(posedge clk) disable iff (rst)
    (done && !equivalent_mode) |-> (first_offset == '0))
    else $error("offset nonzero in real-time mode");

  a_rd_sign: assert property (@(posedge clk) disable iff (rst)
    (done && (read_delta != '0)) |-> read_delta[spcc_pkg::RD_W-1])
    else $error("read delta positive");

endmodule

bind scope_pretrigger_count_calc_core spcc_checker u_spcc_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pre-trigger count calculator. Time shifts go
// through a start/busy driver; a monitor matches every done-strobed result,
// field by field, against the launch words predicted from a mirror of the
// configuration. The run walks directed corner settings, then random
// settings and shifts, with the sender idling at 13%, 62% and 0%.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [spcc_pkg::WORD_W-1:0]      pre_word;
    logic [spcc_pkg::WORD_W-1:0]      post_word;
    logic signed [spcc_pkg::RD_W-1:0] read_delta;
    logic signed [spcc_pkg::R_W-1:0]  first_offset;
    logic                             equivalent_mode;
  } launch_t;

  localparam int REC_PTS   [0:6] = '{281, 512, 1024, 2048, 4096, 8192, 16384};
  localparam int STRETCH   [0:5] = '{100, 50, 20, 10, 5, 2};
  localparam int PRE_FAST  [0:7] = '{10, 10, 10, 10, 10, 10, 5, 3};
  localparam int POST_FAST [0:7] = '{10, 10, 20, 10, 10, 10, 5, 3};
  localparam int N_SETS      = 20;
  localparam int SET_ITEMS   = 55;
  localparam int MAX_REPORTS = 10;

  logic                                  clk;
  logic                                  rst = 1'b1;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [spcc_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [spcc_pkg::CFG_DATA_W-1:0]       cfg_data = '0;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic signed [spcc_pkg::TS_W-1:0]      time_shift = '0;
  logic                                  done;
  logic [spcc_pkg::WORD_W-1:0]           pre_word;
  logic [spcc_pkg::WORD_W-1:0]           post_word;
  logic signed [spcc_pkg::RD_W-1:0]      read_delta;
  logic signed [spcc_pkg::R_W-1:0]       first_offset;
  logic                                  equivalent_mode;

  // configuration mirror
  logic [spcc_pkg::TB_W-1:0]   tbase_cfg = '0;
  logic [spcc_pkg::TRIG_W-1:0] trig_cfg = '0;
  logic [spcc_pkg::PSEL_W-1:0] psel_cfg = '0;
  logic                        peak_cfg = 1'b0;

  logic signed [spcc_pkg::TS_W-1:0] shift_q [$];
  launch_t                          launch_q [$];
  int                               idle_pct = 13;
  int                               fail_cnt = 0;

  scope_pretrigger_count_calc_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .time_shift      (time_shift),
    .done            (done),
    .pre_word        (pre_word),
    .post_word       (post_word),
    .read_delta      (read_delta),
    .first_offset    (first_offset),
    .equivalent_mode (equivalent_mode)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d launches still pending", launch_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int rec_points();
    return REC_PTS[(psel_cfg > spcc_pkg::PSEL_MAX) ? spcc_pkg::PSEL_MAX : psel_cfg];
  endfunction

  function automatic launch_t calc_launch(logic signed [spcc_pkg::TS_W-1:0] ts);
    launch_t r;
    int base, points, tshift, min_shift, shift, pre, post, step;
    int pre_sum, post_sum, rd, off;
    bit equiv;
    base   = (tbase_cfg > spcc_pkg::TB_MAX) ? spcc_pkg::TB_MAX : tbase_cfg;
    points = rec_points();
    tshift = ts;
    equiv  = (base <= spcc_pkg::RANDOMIZE_MAX_BASE);
    case (trig_cfg)
      spcc_pkg::TRIG_CENTER: min_shift = -points / 2;
      spcc_pkg::TRIG_RIGHT:  min_shift = 0;
      default:               min_shift = -points;   // code 3 falls back to left
    endcase
    shift = tshift - min_shift;
    step  = equiv ? STRETCH[base] : 1;
    if (equiv) begin
      post = shift / step;
      pre  = points / step - post;
    end else begin
      post = shift / 2;
      pre  = points / 2 - post;
      if (pre < 0) pre = 0;
      if (shift < 0) post = 0;
    end
    pre_sum  = pre + ((base < 8) ? PRE_FAST[base] : 1);
    post_sum = post + ((base < 8) ? POST_FAST[base] : 1);
    if (peak_cfg) begin
      pre_sum  = pre_sum * 2;
      post_sum = post_sum * 2;
    end
    rd  = (shift < 0) ? shift : 0;
    off = -(tshift % step);
    r.pre_word        = ~spcc_pkg::WORD_W'(pre_sum);
    r.post_word       = ~spcc_pkg::WORD_W'(post_sum);
    r.read_delta      = spcc_pkg::RD_W'(rd);
    r.first_offset    = spcc_pkg::R_W'(off);
    r.equivalent_mode = equiv;
    return r;
  endfunction

  // shifts span the full range, cluster around zero and the two trigger-dependent minimum shifts, or hit the range ends
  function automatic logic signed [spcc_pkg::TS_W-1:0] pick_shift();
    int p, v;
    p = rec_points();
    case ($urandom_range(0, 4))
      0, 1: v = int'($urandom_range(0, 32767)) - 16384;
      2:    v = int'($urandom_range(0, 400)) - 200;
      3:    v = (($urandom_range(0, 1) != 0) ? -p : -(p / 2))
                + int'($urandom_range(0, 400)) - 200;
      default: v = ($urandom_range(0, 1) != 0) ? -16384 : 16383;
    endcase
    return spcc_pkg::TS_W'(v);
  endfunction

  task automatic cfg_write(input logic [spcc_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [spcc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      spcc_pkg::CFG_TIME_BASE:  tbase_cfg = data[spcc_pkg::TB_W-1:0];
      spcc_pkg::CFG_TRIG_POS:   trig_cfg  = data[spcc_pkg::TRIG_W-1:0];
      spcc_pkg::CFG_POINTS_SEL: psel_cfg  = data[spcc_pkg::PSEL_W-1:0];
      spcc_pkg::CFG_PEAK_DET:   peak_cfg  = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits are randomized; unknown indexes get stray writes
  task automatic apply_cfg(input int tb, input int tp, input int ps, input int pk);
    logic [spcc_pkg::CFG_DATA_W-1:0] d;
    int                              xi;
    cfg_write(spcc_pkg::CFG_TIME_BASE, spcc_pkg::CFG_DATA_W'(tb));
    d = spcc_pkg::CFG_DATA_W'($urandom);
    d[spcc_pkg::TRIG_W-1:0] = spcc_pkg::TRIG_W'(tp);
    cfg_write(spcc_pkg::CFG_TRIG_POS, d);
    d = spcc_pkg::CFG_DATA_W'($urandom);
    d[spcc_pkg::PSEL_W-1:0] = spcc_pkg::PSEL_W'(ps);
    cfg_write(spcc_pkg::CFG_POINTS_SEL, d);
    d = spcc_pkg::CFG_DATA_W'($urandom);
    d[0] = pk[0];
    cfg_write(spcc_pkg::CFG_PEAK_DET, d);
    if ($urandom_range(0, 3) == 0) begin
      xi = $urandom_range(spcc_pkg::CFG_PEAK_DET + 1, (1 << spcc_pkg::CFG_IDX_W) - 1);
      cfg_write(spcc_pkg::CFG_IDX_W'(xi), spcc_pkg::CFG_DATA_W'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (shift_q.size() != 0 || start || launch_q.size() != 0) @(posedge clk);
  endtask

  // driver: start holds until the transaction is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        launch_q.push_back(calc_launch(time_shift));
      if (!(start && busy)) begin
        if (shift_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start      <= 1'b1;
          time_shift <= shift_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, take each one in its done cycle
  always @(posedge clk) begin
    launch_t e;
    if (!rst && done) begin
      if (launch_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result at %0t", $realtime);
      end else begin
        e = launch_q.pop_front();
        if (pre_word !== e.pre_word || post_word !== e.post_word ||
            read_delta !== e.read_delta || first_offset !== e.first_offset ||
            equivalent_mode !== e.equivalent_mode) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $write("mismatch at %0t: exp pre %h post %h rd %h off %h eq %b,",
                   $realtime, e.pre_word, e.post_word, e.read_delta, e.first_offset,
                   e.equivalent_mode);
            $display(" got pre %h post %h rd %h off %h eq %b",
                     pre_word, post_word, read_delta, first_offset, equivalent_mode);
          end
        end
      end
    end
  end

  initial begin
    int corner_tb [0:4] = '{0, 5, 31, 6, 30};
    int corner_tp [0:4] = '{0, 2, 3, 1, 1};
    int corner_ps [0:4] = '{0, 6, 7, 0, 6};
    int corner_pk [0:4] = '{0, 1, 1, 0, 1};
    int tb;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corner settings: fastest/slowest timebase, out-of-range codes
    for (int c = 0; c < 5; c++) begin
      apply_cfg(corner_tb[c], corner_tp[c], corner_ps[c], corner_pk[c]);
      shift_q.push_back(spcc_pkg::TS_W'(-16384));
      shift_q.push_back(spcc_pkg::TS_W'(16383));
      shift_q.push_back(spcc_pkg::TS_W'(0));
      shift_q.push_back(spcc_pkg::TS_W'(-1));
      shift_q.push_back(spcc_pkg::TS_W'(-rec_points()));
      wait_idle();
    end

    for (int s = 0; s < N_SETS; s++) begin
      idle_pct = (s < 7) ? 13 : (s < 14) ? 62 : 0;
      case ($urandom_range(0, 3))
        0, 1:    tb = $urandom_range(0, 7);
        2:       tb = $urandom_range(8, 31);
        default: tb = $urandom_range(spcc_pkg::TB_MAX, 31);
      endcase
      apply_cfg(tb, $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 1));
      for (int i = 0; i < SET_ITEMS; i++)
        shift_q.push_back(pick_shift());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
